[hdl/tbebd_pkg.sv]
// Shared constants and payload types for the two-band energy beat detector.
// No dependencies; every other file of the block refers to this package.
`timescale 1ns / 1ps

package tbebd_pkg;

   localparam int unsigned MAG_W                 = 16;
   localparam int unsigned RATIO_W               = 16;
   localparam int unsigned FRAC_BITS             = 12;
   localparam int unsigned HISTORY_DEPTH_DEFAULT = 32;

   // About 1.15 in unsigned Q4.12.
   localparam logic [RATIO_W-1:0] RATIO_RESET = 16'd4710;

   typedef struct packed {
      logic [MAG_W-1:0] low_bin_magnitude;
      logic [MAG_W-1:0] high_bin_magnitude;
   } req_payload_type;

   typedef struct packed {
      logic             beat;
      logic [MAG_W-1:0] low_bin_average;
      logic [MAG_W-1:0] high_bin_average;
   } rsp_payload_type;

endpackage

[hdl/tbebd_intf.sv]
// Valid/ready channel interfaces for the request and response sides.
// Depends on tbebd_pkg for the payload types.
`timescale 1ns / 1ps

interface tbebd_req_if;
   logic                       valid;
   logic                       ready;
   tbebd_pkg::req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface tbebd_rsp_if;
   logic                       valid;
   logic                       ready;
   tbebd_pkg::rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

[hdl/two_band_energy_beat_detector.sv]
// Top level of the two-band energy beat detector: history ring memory,
// running sums, threshold compare and average divide in a four-stage pipeline.
// Depends on tbebd_pkg and the channel interfaces in tbebd_intf.sv.
//
//   channel   direction   role
//   req_ch    in          one spectrum frame: low and high bin magnitudes
//   rsp_ch    out         beat flag and both ring averages
//   csr_*     in          write-only beat ratio register (Q4.12)
//
// One transaction per clock is sustained while rsp_ch is ready; each result passes
// the ring read, then sum update, multiply and compare, and is registered at the output.
// The ring memory read and write-back sit in separate stages, each slot is
// written back as its request leaves stage 1 and the next transaction reads the next
// slot. Reset is synchronous and needs no clearing pass: a fill flag makes
// slots that were never written read as zero. Stages hold under back-pressure
// and empty stages keep filling, so requests are taken while a result waits.
`timescale 1ns / 1ps

module two_band_energy_beat_detector #(
   parameter int unsigned HISTORY_DEPTH = tbebd_pkg::HISTORY_DEPTH_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   tbebd_req_if.sink                      req_ch,
   tbebd_rsp_if.source                    rsp_ch,
   input  logic                           csr_we,
   input  logic [tbebd_pkg::RATIO_W-1:0]  csr_wdata
);

   localparam int unsigned MAG_W   = tbebd_pkg::MAG_W;
   localparam int unsigned RATIO_W = tbebd_pkg::RATIO_W;
   localparam int unsigned FRAC_B  = tbebd_pkg::FRAC_BITS;
   localparam int unsigned AW      = $clog2(HISTORY_DEPTH);
   localparam int unsigned SUM_W   = MAG_W + AW;
   localparam int unsigned SHIFT   = SUM_W + AW;
   localparam int unsigned RECIP_W = SUM_W + 1;
   localparam int unsigned AVGP_W  = SUM_W + RECIP_W;
   localparam int unsigned THR_W   = RATIO_W + SUM_W;

   // Rounded-up reciprocal; with SHIFT this wide the quotient is exact for
   // every sum the ring can hold.
   localparam logic [63:0] RECIP_FULL =
      ((64'd1 << SHIFT) + 64'(HISTORY_DEPTH) - 64'd1) / 64'(HISTORY_DEPTH);
   localparam logic [RECIP_W-1:0] RECIP   = RECIP_FULL[RECIP_W-1:0];
   localparam logic [AW-1:0]      LAST    = AW'(HISTORY_DEPTH - 1);
   localparam logic [SUM_W-1:0]   DEPTH_K = SUM_W'(HISTORY_DEPTH);
   localparam logic [SUM_W-1:0]   SUM_MAX = SUM_W'(HISTORY_DEPTH * ((1 << MAG_W) - 1));

   // ---------------------------------------------------------------- control
   logic [RATIO_W-1:0]   beat_ratio_ff;
   logic [AW-1:0]        wp_ff, wp_in;
   logic                 wrapped_ff, wrapped_in;
   logic                 v1_ff, v1_in, v2_ff, v2_in, v3_ff, v3_in, ovld_ff, ovld_in;
   logic                 acc, rdy_o, rdy3, rdy2, adv1, adv2, adv3;

   assign acc   = req_ch.valid && req_ch.ready;
   assign rdy_o = !ovld_ff || rsp_ch.ready;
   assign rdy3  = !v3_ff || rdy_o;
   assign rdy2  = !v2_ff || rdy3;
   assign req_ch.ready = !v1_ff || rdy2;
   assign adv1  = v1_ff && rdy2;
   assign adv2  = v2_ff && rdy3;
   assign adv3  = v3_ff && rdy_o;

   assign v1_in   = acc  || (v1_ff && !adv1);
   assign v2_in   = adv1 || (v2_ff && !adv2);
   assign v3_in   = adv2 || (v3_ff && !adv3);
   assign ovld_in = adv3 || (ovld_ff && !rsp_ch.ready);

   assign wp_in      = !acc ? wp_ff : ((wp_ff == LAST) ? '0 : wp_ff + 1'b1);
   assign wrapped_in = wrapped_ff || (acc && (wp_ff == LAST));

   always_ff @(posedge clock) begin
      if (reset) begin
         beat_ratio_ff <= tbebd_pkg::RATIO_RESET;
         wp_ff         <= '0;
         wrapped_ff    <= 1'b0;
         v1_ff         <= 1'b0;
         v2_ff         <= 1'b0;
         v3_ff         <= 1'b0;
         ovld_ff       <= 1'b0;
      end else begin
         if (csr_we) begin
            beat_ratio_ff <= csr_wdata;
         end
         wp_ff      <= wp_in;
         wrapped_ff <= wrapped_in;
         v1_ff      <= v1_in;
         v2_ff      <= v2_in;
         v3_ff      <= v3_in;
         ovld_ff    <= ovld_in;
      end
   end

   // ------------------------------------------------ ring memory, stage 1
   logic [2*MAG_W-1:0] hist_mem [HISTORY_DEPTH];
   logic [2*MAG_W-1:0] hist_rd_ff;
   logic [MAG_W-1:0]   lo1_ff, hi1_ff;
   logic [AW-1:0]      slot1_ff;
   logic               old_zero1_ff;
   logic [MAG_W-1:0]   old_lo, old_hi;
   logic [SUM_W-1:0]   lo_sum_ff, lo_sum_in, hi_sum_ff, hi_sum_in;

   always_ff @(posedge clock) begin
      if (acc) begin
         hist_rd_ff <= hist_mem[wp_ff];
      end
      if (adv1) begin
         hist_mem[slot1_ff] <= {hi1_ff, lo1_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (acc) begin
         lo1_ff       <= req_ch.payload.low_bin_magnitude;
         hi1_ff       <= req_ch.payload.high_bin_magnitude;
         slot1_ff     <= wp_ff;
         old_zero1_ff <= !wrapped_ff;
      end
   end

   // A slot that has not been written since reset reads as zero.
   assign old_lo = old_zero1_ff ? '0 : hist_rd_ff[MAG_W-1:0];
   assign old_hi = old_zero1_ff ? '0 : hist_rd_ff[2*MAG_W-1:MAG_W];

   assign lo_sum_in = lo_sum_ff - SUM_W'(old_lo) + SUM_W'(lo1_ff);
   assign hi_sum_in = hi_sum_ff - SUM_W'(old_hi) + SUM_W'(hi1_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         lo_sum_ff <= '0;
         hi_sum_ff <= '0;
      end else if (adv1) begin
         lo_sum_ff <= lo_sum_in;
         hi_sum_ff <= hi_sum_in;
      end
   end

   // ------------------------------------------------ stage 2: multiplies
   logic [MAG_W-1:0]  lo2_ff, hi2_ff;
   logic [SUM_W-1:0]  lo_sum2_ff, hi_sum2_ff;
   logic [THR_W-1:0]  lo_thr_in, hi_thr_in, lo_thr3_ff, hi_thr3_ff;
   logic [SUM_W-1:0]  lo_lhs_in, hi_lhs_in, lo_lhs3_ff, hi_lhs3_ff;
   logic [AVGP_W-1:0] lo_avgp_in, hi_avgp_in, lo_avgp3_ff, hi_avgp3_ff;

   always_ff @(posedge clock) begin
      if (adv1) begin
         lo2_ff     <= lo1_ff;
         hi2_ff     <= hi1_ff;
         lo_sum2_ff <= lo_sum_in;
         hi_sum2_ff <= hi_sum_in;
      end
   end

   assign lo_thr_in  = THR_W'(beat_ratio_ff) * THR_W'(lo_sum2_ff);
   assign hi_thr_in  = THR_W'(beat_ratio_ff) * THR_W'(hi_sum2_ff);
   assign lo_lhs_in  = SUM_W'(lo2_ff) * DEPTH_K;
   assign hi_lhs_in  = SUM_W'(hi2_ff) * DEPTH_K;
   assign lo_avgp_in = AVGP_W'(lo_sum2_ff) * AVGP_W'(RECIP);
   assign hi_avgp_in = AVGP_W'(hi_sum2_ff) * AVGP_W'(RECIP);

   always_ff @(posedge clock) begin
      if (adv2) begin
         lo_thr3_ff  <= lo_thr_in;
         hi_thr3_ff  <= hi_thr_in;
         lo_lhs3_ff  <= lo_lhs_in;
         hi_lhs3_ff  <= hi_lhs_in;
         lo_avgp3_ff <= lo_avgp_in;
         hi_avgp3_ff <= hi_avgp_in;
      end
   end

   // ------------------------------------------------ stage 3: compare, output
   logic                       lo_hit, hi_hit;
   tbebd_pkg::rsp_payload_type rsp_in, rsp_ff;

   assign lo_hit = THR_W'({lo_lhs3_ff, {FRAC_B{1'b0}}}) >= lo_thr3_ff;
   assign hi_hit = THR_W'({hi_lhs3_ff, {FRAC_B{1'b0}}}) >= hi_thr3_ff;

   always_comb begin
      rsp_in.beat             = lo_hit || hi_hit;
      rsp_in.low_bin_average  = lo_avgp3_ff[SHIFT +: MAG_W];
      rsp_in.high_bin_average = hi_avgp3_ff[SHIFT +: MAG_W];
   end

   always_ff @(posedge clock) begin
      if (adv3) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_ch.valid   = ovld_ff;
   assign rsp_ch.payload = rsp_ff;

   // ------------------------------------------------ assertions
   logic [AW-1:0] slot1_next;
   assign slot1_next = (slot1_ff == LAST) ? '0 : slot1_ff + 1'b1;

   a_port_conflict: assert property (@(posedge clock) disable iff (reset)
      (acc && adv1) |-> (wp_ff != slot1_ff))
      else $error("ring read and write-back hit the same slot in one cycle");

   a_slot_order: assert property (@(posedge clock) disable iff (reset)
      v1_ff |-> (wp_ff == slot1_next))
      else $error("write pointer is not one slot past the transaction in stage 1");

   a_sum_bound: assert property (@(posedge clock) disable iff (reset)
      (lo_sum_ff <= SUM_MAX) && (hi_sum_ff <= SUM_MAX))
      else $error("running sum exceeds the largest possible ring total");

   a_wrap_sticky: assert property (@(posedge clock) disable iff (reset)
      (wrapped_ff && !reset) |=> (wrapped_ff || $past(reset)))
      else $error("fill flag dropped without a reset");

endmodule
